// File: rtl/core/scaled_decimal_divide_round_even_top_assert.svh
// Assertion macros for the scaled decimal divider.
`ifndef SCALED_DECIMAL_DIVIDE_ROUND_EVEN_TOP_ASSERT_SVH
`define SCALED_DECIMAL_DIVIDE_ROUND_EVEN_TOP_ASSERT_SVH

`define SDD_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`define SDD_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: rtl/core/sdd_pkg.sv
package sdd_pkg;
    localparam int WideW = 128;
    localparam int ExpW  = 6;
    localparam int SelW  = 2;
    localparam int PowEntries = 39;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NUM_OVF  = 2'd3
    } t_status;

    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_WSEL  = 1'b1;

    // Per-item control that rides alongside the divider datapath.
    typedef struct packed {
        logic    neg;
        logic    err;
        t_status status;
        logic [SelW-1:0] wsel;
    } t_ctrl;

    typedef logic [PowEntries-1:0][WideW-1:0] t_pow_tab;

    // 10^e for e in 0..38; all fit in 127 bits.
    function automatic t_pow_tab pow10_table();
        t_pow_tab tab;
        tab[0] = 128'd1;
        for (int k = 1; k < PowEntries; k++) begin
            tab[k] = (tab[k-1] << 3) + (tab[k-1] << 1);
        end
        return tab;
    endfunction

    localparam t_pow_tab Pow10Tab = pow10_table();
endpackage

// File: rtl/core/sdd_front.sv
// Stage chain: magnitudes, power table lookup, scaled numerator with overflow check.
module sdd_front #(
    parameter int POWER_TABLE_ENTRIES = 39
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [127:0]          i_a,
    input  logic [127:0]          i_b,
    input  logic [5:0]            i_exp,
    input  logic [1:0]            i_wsel,
    output logic                  o_valid,
    output logic [127:0]          o_num,
    output logic [127:0]          o_den,
    output sdd_pkg::t_ctrl        o_ctrl
);
    import sdd_pkg::*;

    function automatic logic [63:0] mul32(input logic [31:0] x, input logic [31:0] y);
        return {32'd0, x} * {32'd0, y};
    endfunction

    logic         r_v1;
    logic [127:0] r_am, r_bm, r_pw;
    t_ctrl        r_c1;
    logic         r_an;

    logic [127:0] n_am, n_bm;
    t_ctrl        n_c1;

    always_comb begin
        n_am = i_a[127] ? (~i_a + 128'd1) : i_a;
        n_bm = i_b[127] ? (~i_b + 128'd1) : i_b;
        n_c1.neg    = i_a[127] ^ i_b[127];
        n_c1.wsel   = i_wsel;
        n_c1.err    = 1'b0;
        n_c1.status = ST_OK;
        if (i_b == '0) begin
            n_c1.err = 1'b1;
            n_c1.status = ST_DIV_ZERO;
        end else if (int'(i_exp) >= POWER_TABLE_ENTRIES) begin
            n_c1.err = 1'b1;
            n_c1.status = ST_NUM_OVF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_am <= n_am;
            r_bm <= n_bm;
            r_pw <= (int'(i_exp) < PowEntries) ? Pow10Tab[i_exp] : '0;
            r_c1 <= n_c1;
            r_an <= i_a[127];
        end
    end

    // 32x32 partials below 2^128; partials at 2^128 and above only need a nonzero test.
    logic         r_v2;
    logic [63:0]  r_m00, r_m01, r_m10, r_m02, r_m11, r_m20, r_m03, r_m12, r_m21, r_m30;
    logic         r_ovh2;
    logic [127:0] r_bm2;
    t_ctrl        r_c2;
    logic         r_an2;

    logic [3:0]   n_anz, n_pnz;
    logic         n_ovh;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_anz[k] = (r_am[32*k +: 32] != '0);
            n_pnz[k] = (r_pw[32*k +: 32] != '0);
        end
        n_ovh = (n_anz[3] && (|n_pnz[3:1])) || (n_anz[2] && (|n_pnz[3:2])) ||
                (n_anz[1] && n_pnz[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_m00  <= mul32(r_am[31:0],   r_pw[31:0]);
            r_m01  <= mul32(r_am[31:0],   r_pw[63:32]);
            r_m10  <= mul32(r_am[63:32],  r_pw[31:0]);
            r_m02  <= mul32(r_am[31:0],   r_pw[95:64]);
            r_m11  <= mul32(r_am[63:32],  r_pw[63:32]);
            r_m20  <= mul32(r_am[95:64],  r_pw[31:0]);
            r_m03  <= mul32(r_am[31:0],   r_pw[127:96]);
            r_m12  <= mul32(r_am[63:32],  r_pw[95:64]);
            r_m21  <= mul32(r_am[95:64],  r_pw[63:32]);
            r_m30  <= mul32(r_am[127:96], r_pw[31:0]);
            r_ovh2 <= n_ovh;
            r_bm2  <= r_bm;
            r_c2   <= r_c1;
            r_an2  <= r_an;
        end
    end

    // Column sums per 32-bit weight.
    logic         r_v3;
    logic [63:0]  r_w0;
    logic [64:0]  r_w1;
    logic [65:0]  r_w2, r_w3;
    logic         r_ovh3;
    logic [127:0] r_bm3;
    t_ctrl        r_c3;
    logic         r_an3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_w0   <= r_m00;
            r_w1   <= {1'b0, r_m01} + {1'b0, r_m10};
            r_w2   <= {2'b0, r_m02} + {2'b0, r_m11} + {2'b0, r_m20};
            r_w3   <= {2'b0, r_m03} + {2'b0, r_m12} + {2'b0, r_m21} + {2'b0, r_m30};
            r_ovh3 <= r_ovh2;
            r_bm3  <= r_bm2;
            r_c3   <= r_c2;
            r_an3  <= r_an2;
        end
    end

    logic [162:0] n_sum;
    logic [127:0] n_nm;
    logic         n_ovf;
    t_ctrl        n_c4;

    always_comb begin
        n_sum = {99'd0, r_w0} + {66'd0, r_w1, 32'd0} + {33'd0, r_w2, 64'd0} +
                {1'b0, r_w3, 96'd0};
        n_nm  = n_sum[127:0];
        n_ovf = r_ovh3 || (n_sum[162:128] != '0);
        if (r_an3) begin
            n_ovf = n_ovf || (n_nm > {1'b1, 127'd0});
        end else begin
            n_ovf = n_ovf || n_nm[127];
        end
        n_c4 = r_c3;
        if (n_nm == '0) begin
            n_c4.neg = 1'b0;
        end
        if (!r_c3.err && n_ovf) begin
            n_c4.err = 1'b1;
            n_c4.status = ST_NUM_OVF;
        end
    end

    logic         r_v4;
    logic [127:0] r_nm, r_bm4;
    t_ctrl        r_c4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
        if (i_en) begin
            r_nm  <= n_nm;
            r_bm4 <= r_bm3;
            r_c4  <= n_c4;
        end
    end

    assign o_valid = r_v4;
    assign o_num   = r_nm;
    assign o_den   = r_bm4;
    assign o_ctrl  = r_c4;
endmodule

// File: rtl/core/sdd_div.sv
// Restoring divider, one quotient bit per stage, 128 stages.
module sdd_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [127:0]   i_num,
    input  logic [127:0]   i_den,
    input  sdd_pkg::t_ctrl i_ctrl,
    output logic           o_valid,
    output logic [127:0]   o_quo,
    output logic [127:0]   o_rem,
    output logic [127:0]   o_den,
    output sdd_pkg::t_ctrl o_ctrl
);
    import sdd_pkg::*;

    localparam int Steps = 128;

    logic           r_v   [Steps];
    logic [127:0]   r_n   [Steps];
    logic [127:0]   r_r   [Steps];
    logic [127:0]   r_d   [Steps];
    t_ctrl          r_c   [Steps];

    for (genvar s = 0; s < Steps; s++) begin : g_step
        logic         s_v;
        logic [127:0] s_n, s_r, s_d;
        t_ctrl        s_c;
        logic [128:0] n_rs;
        logic [128:0] n_df;
        if (s == 0) begin : g_src
            assign s_v = i_valid;
            assign s_n = i_num;
            assign s_r = '0;
            assign s_d = i_den;
            assign s_c = i_ctrl;
        end else begin : g_src
            assign s_v = r_v[s-1];
            assign s_n = r_n[s-1];
            assign s_r = r_r[s-1];
            assign s_d = r_d[s-1];
            assign s_c = r_c[s-1];
        end
        assign n_rs = {s_r, s_n[127]};
        assign n_df = n_rs - {1'b0, s_d};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= s_v;
            end
            if (i_en) begin
                r_d[s] <= s_d;
                r_c[s] <= s_c;
                if (!n_df[128]) begin
                    r_r[s] <= n_df[127:0];
                    r_n[s] <= {s_n[126:0], 1'b1};
                end else begin
                    r_r[s] <= n_rs[127:0];
                    r_n[s] <= {s_n[126:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[Steps-1];
    assign o_quo   = r_n[Steps-1];
    assign o_rem   = r_r[Steps-1];
    assign o_den   = r_d[Steps-1];
    assign o_ctrl  = r_c[Steps-1];
endmodule

// File: rtl/core/sdd_back.sv
// Round half to even, range check, sign restore.
module sdd_back #(
    parameter int DATA_WIDTH = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [127:0]   i_quo,
    input  logic [127:0]   i_rem,
    input  logic [127:0]   i_den,
    input  sdd_pkg::t_ctrl i_ctrl,
    output logic           o_valid,
    output logic [127:0]   o_res,
    output logic [1:0]     o_status
);
    import sdd_pkg::*;

    logic [127:0] n_dist, n_q;
    logic         n_up;

    always_comb begin
        n_dist = i_den - i_rem;
        n_up = (n_dist < i_rem) || ((n_dist == i_rem) && i_quo[0]);
        n_q = i_quo + {127'd0, n_up};
    end

    logic         r_v1;
    logic [127:0] r_q;
    t_ctrl        r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_q <= n_q;
            r_c <= i_ctrl;
        end
    end

    logic [7:0]   n_w;
    logic [127:0] n_lim;
    logic         n_bad;
    logic [127:0] n_res;
    t_status      n_st;

    always_comb begin
        n_w = 8'd16 << r_c.wsel;
        if (int'(n_w) > DATA_WIDTH) begin
            n_w = 8'(DATA_WIDTH);
        end
        n_lim = 128'd1 << (n_w - 8'd1);
        n_bad = r_c.neg ? (r_q > n_lim) : (r_q >= n_lim);
        n_st  = r_c.status;
        n_res = r_c.neg ? (~r_q + 128'd1) : r_q;
        if (!r_c.err && n_bad) begin
            n_st = ST_RANGE;
        end
        if (r_c.err || n_bad) begin
            n_res = '0;
        end
    end

    logic         r_v2;
    logic [127:0] r_res;
    logic [1:0]   r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_res <= n_res;
            r_st  <= n_st;
        end
    end

    assign o_valid  = r_v2;
    assign o_res    = r_res;
    assign o_status = r_st;
endmodule

// File: rtl/core/scaled_decimal_divide_round_even_top.sv
// Scaled decimal divider, 128-bit signed operands, rounding half to even.
// Input channel: i_in_valid / o_in_ready with the dividend and divisor halves.
// Output channel: o_out_valid / i_out_ready with quotient halves and status.
// Config: i_cfg_we, i_cfg_index, i_cfg_data; 0 = scale exponent, 1 = width select.
// Write configuration only while no item is in flight.
// Throughput: one item per cycle while the pipe is not held for a waiting skid entry.
// Path from input to o_out_valid: 4 front stages, 128 divider stages, 2 rounding
// stages, 1 output register.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, a one-entry skid register catches the item leaving the
// pipe, and the pipe then holds until the skid drains. Nothing is dropped.
// Reset clears all valid bits and sets scale 0 and 128-bit range.
// Status: 0 ok, 1 divide by zero, 2 out of range, 3 numerator overflow;
// the quotient is zero whenever status is nonzero.
module scaled_decimal_divide_round_even_top #(
    parameter int DATA_WIDTH          = 128,
    parameter int POWER_TABLE_ENTRIES = 39
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [5:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [63:0] i_dividend_high,
    input  logic [63:0]        i_dividend_low,
    input  logic signed [63:0] i_divisor_high,
    input  logic [63:0]        i_divisor_low,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [63:0] o_quotient_high,
    output logic [63:0]        o_quotient_low,
    output logic [1:0]         o_status
);
    import sdd_pkg::*;

    logic [5:0] r_exp;
    logic [1:0] r_wsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= '0;
            r_wsel <= 2'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCALE: r_exp  <= i_cfg_data;
                CFG_WSEL:  r_wsel <= i_cfg_data[1:0];
                default:   r_exp  <= r_exp;
            endcase
        end
    end

    logic         en;
    logic         f_v, d_v, b_v;
    logic [127:0] f_num, f_den, d_quo, d_rem, d_den, b_res;
    t_ctrl        f_c, d_c;
    logic [1:0]   b_st;

    logic         r_ov, r_sv;
    logic [127:0] r_ores, r_sres;
    logic [1:0]   r_ost, r_sst;

    assign en = !r_sv;
    assign o_in_ready = en;

    sdd_front #(.POWER_TABLE_ENTRIES(POWER_TABLE_ENTRIES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in_valid),
        .i_a({i_dividend_high, i_dividend_low}), .i_b({i_divisor_high, i_divisor_low}),
        .i_exp(r_exp), .i_wsel(r_wsel),
        .o_valid(f_v), .o_num(f_num), .o_den(f_den), .o_ctrl(f_c)
    );

    sdd_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(f_v),
        .i_num(f_num), .i_den(f_den), .i_ctrl(f_c),
        .o_valid(d_v), .o_quo(d_quo), .o_rem(d_rem), .o_den(d_den), .o_ctrl(d_c)
    );

    sdd_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(d_v),
        .i_quo(d_quo), .i_rem(d_rem), .i_den(d_den), .i_ctrl(d_c),
        .o_valid(b_v), .o_res(b_res), .o_status(b_st)
    );

    // Output register plus one skid entry.
    logic n_take;
    assign n_take = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (n_take) begin
                if (r_sv) begin
                    r_ov <= 1'b1;
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= en && b_v;
                end
            end else if (en && b_v) begin
                r_sv <= 1'b1;
            end
        end
        if (n_take) begin
            if (r_sv) begin
                r_ores <= r_sres;
                r_ost  <= r_sst;
            end else begin
                r_ores <= b_res;
                r_ost  <= b_st;
            end
        end else if (en && b_v) begin
            r_sres <= b_res;
            r_sst  <= b_st;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_quotient_high = r_ores[127:64];
    assign o_quotient_low  = r_ores[63:0];
    assign o_status        = r_ost;

`include "scaled_decimal_divide_round_even_top_assert.svh"

    `SDD_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_sv, r_ov)
    `SDD_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, r_ov && (r_ost != ST_OK), r_ores == '0)
    `SDD_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, r_ov && !i_out_ready, r_ov && $stable(r_ores))
endmodule

// File: verif/scaled_decimal_divide_round_even_top_tb.sv
module scaled_decimal_divide_round_even_top_tb;
    import sdd_pkg::*;

    typedef struct {
        logic [63:0] q_hi;
        logic [63:0] q_lo;
        t_status     status;
    } t_quot;

    class quotient_board;
        t_quot       pending[$];
        logic [5:0]  cur_scale;
        logic [1:0]  width_sel;
        int          n_err;

        function new();
            cur_scale = 6'd0;
            width_sel = 2'd3;
            n_err     = 0;
        endfunction

        function automatic t_quot divide_rounded(logic [127:0] a, logic [127:0] b);
            t_quot       res;
            logic [255:0] prod;
            logic [127:0] p10, am, bm, nm, q, r, gap, lim;
            logic        an, bn, neg, up;
            int          w;
            res.q_hi = '0;
            res.q_lo = '0;
            res.status = ST_OK;
            an = a[127];
            bn = b[127];
            if (b == '0) begin
                res.status = ST_DIV_ZERO;
                return res;
            end
            if (cur_scale >= 39) begin
                res.status = ST_NUM_OVF;
                return res;
            end
            p10 = 128'd1;
            for (int k = 0; k < cur_scale; k++) p10 = p10 * 128'd10;
            am = an ? -a : a;
            bm = bn ? -b : b;
            prod = {128'd0, am} * {128'd0, p10};
            nm = prod[127:0];
            if (prod[255:128] != '0 ||
                (an ? (nm > {1'b1, 127'd0}) : nm[127])) begin
                res.status = ST_NUM_OVF;
                return res;
            end
            neg = (an != bn) && (nm != '0);
            q = nm / bm;
            r = nm % bm;
            gap = bm - r;
            up = (gap < r) || (gap == r && q[0]);
            if (up) q = q + 128'd1;
            w = 16 << width_sel;
            lim = 128'd1 << (w - 1);
            if (neg ? (q > lim) : (q >= lim)) begin
                res.status = ST_RANGE;
                return res;
            end
            if (neg) q = -q;
            res.q_hi = q[127:64];
            res.q_lo = q[63:0];
            return res;
        endfunction

        function void note_item(logic [127:0] a, logic [127:0] b);
            pending.push_back(divide_rounded(a, b));
        endfunction

        function void check_quotient(logic [63:0] hi, logic [63:0] lo, logic [1:0] st);
            t_quot exp_q;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h %h %0d", hi, lo, st);
                return;
            end
            exp_q = pending.pop_front();
            if (exp_q.q_hi !== hi || exp_q.q_lo !== lo || exp_q.status !== t_status'(st)) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch exp %h_%h st %0d got %h_%h st %0d",
                             exp_q.q_hi, exp_q.q_lo, exp_q.status, hi, lo, st);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [5:0]         i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [63:0] i_dividend_high = '0;
    logic [63:0]        i_dividend_low = '0;
    logic signed [63:0] i_divisor_high = '0;
    logic [63:0]        i_divisor_low = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [63:0] o_quotient_high;
    logic [63:0]        o_quotient_low;
    logic [1:0]         o_status;

    quotient_board board = new();
    int          cycles = 0;
    int          stall_mode = 0;

    scaled_decimal_divide_round_even_top u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: phases of always-ready, random stall, long stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_quotient(o_quotient_high, o_quotient_low, o_status);
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            default: i_out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic cfg_write(logic idx, logic [5:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SCALE) board.cur_scale = val;
        else board.width_sel = val[1:0];
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // drives one item; valid stays high until a gap or a drain lowers it
    task automatic send_item(logic [127:0] a, logic [127:0] b);
        i_in_valid <= 1'b1;
        i_dividend_high <= a[127:64];
        i_dividend_low <= a[63:0];
        i_divisor_high <= b[127:64];
        i_divisor_low <= b[63:0];
        do @(posedge i_clk); while (!o_in_ready);
        board.note_item(a, b);
    endtask

    function automatic logic [127:0] rand_wide();
        logic [127:0] v;
        int kind;
        v = {$urandom, $urandom, $urandom, $urandom};
        kind = $urandom_range(0, 7);
        case (kind)
            0: v = v >> $urandom_range(0, 127);
            1: v = -(v >> $urandom_range(0, 127));
            2: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 127'd0};
            3: v = $urandom_range(0, 1) ? 128'd1 : -128'd1;
            4: v = 128'($urandom_range(0, 20));
            5: v = -128'($urandom_range(0, 20));
            default: ;
        endcase
        return v;
    endfunction

    task automatic burst_run(int n);
        int left;
        int burst;
        logic [127:0] a;
        logic [127:0] b;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            if (burst > left) burst = left;
            for (int k = 0; k < burst; k++) begin
                a = rand_wide();
                b = rand_wide();
                if ($urandom_range(0, 2) == 0) b = b >> $urandom_range(60, 127);
                if ($urandom_range(0, 2) == 0) begin
                    a = $signed(a) >>> $urandom_range(20, 126);
                    b = $signed(b) >>> $urandom_range(100, 126);
                    if (b == '0) b = 128'd2;
                    a = a * b + ($urandom_range(0, 1) ? (b >>> 1) : 128'd0);
                end
                send_item(a, b);
            end
            left -= burst;
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    localparam logic [127:0] MAXP = {1'b0, {127{1'b1}}};
    localparam logic [127:0] MINN = {1'b1, 127'd0};

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_item(128'd7, 128'd0);
        send_item(128'd5, 128'd2);
        send_item(128'd7, 128'd2);
        send_item(-128'd5, 128'd2);
        send_item(-128'd7, 128'd2);
        send_item(MAXP, 128'd1);
        send_item(MINN, 128'd1);
        send_item(MINN, -128'd1);
        send_item(MINN, MINN);
        send_item(MAXP, MINN);
        send_item(128'd0, -128'd3);
        send_item(-128'd1, MAXP);
        drain();
        cfg_write(CFG_SCALE, 6'd38);
        send_item(128'd1, 128'd3);
        send_item(128'd2, 128'd1);
        send_item(-128'd1, 128'd1);
        drain();
        cfg_write(CFG_SCALE, 6'd39);
        send_item(128'd1, 128'd1);
        drain();
        cfg_write(CFG_SCALE, 6'd63);
        send_item(128'd0, 128'd1);
        send_item(128'd1, 128'd0);
        drain();
        cfg_write(CFG_SCALE, 6'd0);
        cfg_write(CFG_WSEL, 6'd0);
        send_item(128'd32767, 128'd1);
        send_item(128'd32768, 128'd1);
        send_item(-128'd32768, 128'd1);
        send_item(-128'd32769, 128'd1);
        send_item(128'd65535, 128'd2);
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(CFG_SCALE, (ph == 7) ? 6'd38 : 6'($urandom_range(0, 45)));
            cfg_write(CFG_WSEL, 6'($urandom_range(0, 3)));
            burst_run(92);
            drain();
        end
        if (board.n_err == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
